// ===== sv/tlvd_pkg.sv =====
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the TLV frame decoder.
// No dependencies; every other file but tlvd_ifs imports this package.
package tlvd_pkg;

	localparam int unsigned MAX_VALUE_BYTES_DEF = 32;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'd1;

	localparam logic [7:0]  START_BYTE_RST = 8'hAA;
	localparam logic [5:0]  MAX_LENGTH_RST = 6'd32;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'h1021;

	typedef enum logic [1:0] {
		ST_BUSY  = 2'd0,
		ST_READY = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		PH_HUNT,
		PH_TAG,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_VALUE,
		PH_CRC_LO,
		PH_CRC_HI,
		PH_FETCH,
		PH_EMIT
	} phase_t;

	typedef enum logic [1:0] {
		OUT_BUSY,
		OUT_ERROR,
		OUT_EMPTY,
		OUT_VALUE
	} out_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic     crc_init;
		logic     crc_upd;
		logic     tag_cap;
		logic     len_lo_cap;
		logic     len_hi_cap;
		logic     rcv_clear;
		logic     value_wr;
		logic     crc_lo_cap;
		logic     rd_clear;
		logic     rd_next;
		logic     out_load;
		out_sel_t out_sel;
	} tlvd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic start_hit;
		logic len_over;
		logic len_zero;
		logic value_done;
		logic crc_match;
		logic held_len_zero;
		logic rd_last;
		logic out_free;
	} tlvd_stat_t;

	// one byte through the MSB-first CRC, eight shift steps
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ===== sv/tlvd_ifs.sv =====
// Valid/ready channel interfaces of the TLV frame decoder: received bytes and results.
// Plain widths, no package dependency.
interface tlvd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface tlvd_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] frame_tag;
	logic [5:0] frame_length;
	logic [7:0] value_byte;
	logic [4:0] value_index;
	logic       byte_valid;
	logic       last;

	modport source (output valid, output status, output frame_tag, output frame_length,
		output value_byte, output value_index, output byte_valid, output last, input ready);
	modport sink (input valid, input status, input frame_tag, input frame_length,
		input value_byte, input value_index, input byte_valid, input last, output ready);
endinterface

// ===== sv/tlv_frame_decoder_crc16.sv =====
// TLV frame decoder with CRC-16/CCITT-FALSE check, top level.
// Depends on tlvd_pkg, tlvd_ifs, tlvd_ctrl and tlvd_datapath.
//
// Usage:
//  - rx: one received byte per transfer (valid/ready). res: result items
//    (valid/ready). cfg_wr_en/cfg_index/cfg_wdata: write-only registers,
//    index 0 start byte, index 1 max value length; write only while idle.
//  - Every byte outside a good frame's CRC gives exactly one result
//    (in progress or error), registered: it shows on res in the cycle after
//    the rx transfer. While the receiver keeps up and no drain runs, rx
//    takes one byte per cycle; the output register lets the next byte in
//    during the same cycle the pending result is transferred.
//  - A good frame of N value bytes: the final CRC byte gives no status
//    result; the N value bytes then drain from the value store, each by a
//    registered read of the store, then a load of the output register,
//    with rx held off until the drain ends. A good zero-length frame gives
//    one result with byte_valid low.
//  - When the receiver stalls, the result stays in the output register and
//    rx.ready drops until it is transferred; nothing is lost.
//  - Reset: parser back to hunting for the start byte, config registers to
//    0xAA / 32, output empty. The value store is not cleared; a frame reads
//    only entries it wrote itself.
module tlv_frame_decoder_crc16
	import tlvd_pkg::*;
#(
	parameter int unsigned MAX_VALUE_BYTES = MAX_VALUE_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	tlvd_rx_if.sink               rx,
	tlvd_res_if.source            res
);

	tlvd_cmd_t  cmd;
	tlvd_stat_t stat;
	logic       in_ready;

	assign rx.ready = in_ready;

	tlvd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tlvd_datapath #(
		.MAX_VALUE_BYTES (MAX_VALUE_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.rx_byte   (rx.rx_byte),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res)
	);

endmodule

// ===== sv/tlvd_ctrl.sv =====
// Parse/drain state machine of the TLV frame decoder.
// Depends on tlvd_pkg; talks to tlvd_datapath through tlvd_cmd_t / tlvd_stat_t.
module tlvd_ctrl
	import tlvd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  tlvd_stat_t stat,
	output tlvd_cmd_t  cmd
);

	phase_t state_q;
	phase_t state_d;
	logic   acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.out_sel = OUT_BUSY;
		in_ready    = 1'b0;
		acc         = 1'b0;
		case (state_q)
			PH_FETCH: begin
				state_d = PH_EMIT;
			end
			PH_EMIT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OUT_VALUE;
					if (stat.rd_last) begin
						state_d = PH_HUNT;
					end else begin
						cmd.rd_next = 1'b1;
						state_d     = PH_FETCH;
					end
				end
			end
			default: begin
				// parsing states: one result per transfer, none for the final CRC byte of a good frame with value bytes
				in_ready = stat.out_free;
				acc      = in_valid && stat.out_free;
				if (acc) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OUT_BUSY;
					case (state_q)
						PH_HUNT: begin
							if (stat.start_hit) begin
								cmd.crc_init = 1'b1;
								state_d      = PH_TAG;
							end
						end
						PH_TAG: begin
							cmd.tag_cap = 1'b1;
							cmd.crc_upd = 1'b1;
							state_d     = PH_LEN_LO;
						end
						PH_LEN_LO: begin
							cmd.len_lo_cap = 1'b1;
							cmd.crc_upd    = 1'b1;
							state_d        = PH_LEN_HI;
						end
						PH_LEN_HI: begin
							cmd.len_hi_cap = 1'b1;
							cmd.crc_upd    = 1'b1;
							cmd.rcv_clear  = 1'b1;
							if (stat.len_over) begin
								cmd.out_sel = OUT_ERROR;
								state_d     = PH_HUNT;
							end else if (stat.len_zero) begin
								state_d = PH_CRC_LO;
							end else begin
								state_d = PH_VALUE;
							end
						end
						PH_VALUE: begin
							cmd.value_wr = 1'b1;
							cmd.crc_upd  = 1'b1;
							if (stat.value_done) begin
								state_d = PH_CRC_LO;
							end
						end
						PH_CRC_LO: begin
							cmd.crc_lo_cap = 1'b1;
							state_d        = PH_CRC_HI;
						end
						PH_CRC_HI: begin
							if (!stat.crc_match) begin
								cmd.out_sel = OUT_ERROR;
								state_d     = PH_HUNT;
							end else if (stat.held_len_zero) begin
								cmd.out_sel = OUT_EMPTY;
								state_d     = PH_HUNT;
							end else begin
								// good frame: no status result, drain the store instead
								cmd.out_load = 1'b0;
								cmd.rd_clear = 1'b1;
								state_d      = PH_FETCH;
							end
						end
						default: begin
							cmd.out_sel = OUT_ERROR;
							state_d     = PH_HUNT;
						end
					endcase
				end
			end
		endcase
	end

endmodule

// ===== sv/tlvd_datapath.sv =====
// Datapath of the TLV frame decoder: config registers, header capture, CRC,
// value store, drain pointer and the result output register. Depends on tlvd_pkg, tlvd_ifs.
module tlvd_datapath
	import tlvd_pkg::*;
#(
	parameter int unsigned MAX_VALUE_BYTES = MAX_VALUE_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic [7:0]            rx_byte,
	input  tlvd_cmd_t             cmd,
	output tlvd_stat_t            stat,
	tlvd_res_if.source            res
);

	localparam int unsigned CNT_W  = $clog2(MAX_VALUE_BYTES + 1);
	localparam int unsigned ADDR_W = (MAX_VALUE_BYTES > 1) ? $clog2(MAX_VALUE_BYTES) : 1;
	localparam logic [15:0] DEPTH16 = 16'(MAX_VALUE_BYTES);

	logic [7:0]       start_byte_q;
	logic [5:0]       max_length_q;
	logic [7:0]       held_tag_q;
	logic [15:0]      held_len_q;
	logic [CNT_W-1:0] rcv_cnt_q;
	logic [7:0]       crc_lo_q;
	logic [15:0]      crc_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [7:0]       rd_data_q;
	logic [7:0]       mem [MAX_VALUE_BYTES];

	logic [15:0] len_full;
	logic [15:0] limit;
	logic [15:0] max_len16;
	logic [31:0] idx_ext;
	logic        out_valid_q;

	assign max_len16 = 16'(max_length_q);
	assign limit     = (max_len16 > DEPTH16) ? DEPTH16 : max_len16;
	assign len_full  = {rx_byte, held_len_q[7:0]};
	assign idx_ext   = 32'(rd_idx_q);

	assign stat.start_hit     = (rx_byte == start_byte_q);
	assign stat.len_over      = (len_full > limit);
	assign stat.len_zero      = (len_full == 16'd0);
	assign stat.value_done    = ((16'(rcv_cnt_q) + 16'd1) >= held_len_q);
	assign stat.crc_match     = ({rx_byte, crc_lo_q} == crc_q);
	assign stat.held_len_zero = (held_len_q == 16'd0);
	assign stat.rd_last       = ((16'(rd_idx_q) + 16'd1) == held_len_q);
	assign stat.out_free      = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			max_length_q <= MAX_LENGTH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_START_BYTE: start_byte_q <= cfg_wdata;
				REG_MAX_LENGTH: max_length_q <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_tag_q <= '0;
			held_len_q <= '0;
			rcv_cnt_q  <= '0;
			crc_lo_q   <= '0;
			crc_q      <= CRC_INIT;
			rd_idx_q   <= '0;
		end else begin
			if (cmd.crc_init) begin
				crc_q <= CRC_INIT;
			end else if (cmd.crc_upd) begin
				crc_q <= crc16_step(crc_q, rx_byte);
			end
			if (cmd.tag_cap) begin
				held_tag_q <= rx_byte;
			end
			if (cmd.len_lo_cap) begin
				held_len_q <= {8'h00, rx_byte};
			end else if (cmd.len_hi_cap) begin
				held_len_q <= len_full;
			end
			if (cmd.rcv_clear) begin
				rcv_cnt_q <= '0;
			end else if (cmd.value_wr) begin
				rcv_cnt_q <= rcv_cnt_q + 1'b1;
			end
			if (cmd.crc_lo_cap) begin
				crc_lo_q <= rx_byte;
			end
			if (cmd.rd_clear) begin
				rd_idx_q <= '0;
			end else if (cmd.rd_next) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	// value store: one write port while parsing, one registered read port for the drain
	always_ff @(posedge clk) begin
		if (cmd.value_wr) begin
			mem[rcv_cnt_q[ADDR_W-1:0]] <= rx_byte;
		end
		rd_data_q <= mem[rd_idx_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res.frame_tag    <= '0;
			res.frame_length <= '0;
			res.value_byte   <= '0;
			res.value_index  <= '0;
			res.byte_valid   <= 1'b0;
			res.last         <= 1'b1;
			case (cmd.out_sel)
				OUT_BUSY: begin
					res.status <= ST_BUSY;
				end
				OUT_EMPTY: begin
					res.status    <= ST_READY;
					res.frame_tag <= held_tag_q;
				end
				OUT_VALUE: begin
					res.status       <= ST_READY;
					res.frame_tag    <= held_tag_q;
					res.frame_length <= held_len_q[5:0];
					res.value_byte   <= rd_data_q;
					res.value_index  <= idx_ext[4:0];
					res.byte_valid   <= 1'b1;
					res.last         <= stat.rd_last;
				end
				default: begin
					res.status <= ST_ERROR;
				end
			endcase
		end
	end

	assign res.valid = out_valid_q;

endmodule

// ===== sv/tlvd_checker.sv =====
// Port-level checks on the TLV frame decoder's result channel, bound to the top level.
// Depends on tlvd_pkg.
module tlvd_checker
	import tlvd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] res_status,
	input logic [7:0] res_frame_tag,
	input logic [5:0] res_frame_length,
	input logic [7:0] res_value_byte,
	input logic [4:0] res_value_index,
	input logic       res_byte_valid,
	input logic       res_last
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_value_byte)
			&& $stable(res_status) && $stable(res_last))
		else $error("result changed while stalled");

	// only good frames span several results
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != ST_READY |-> res_last && !res_byte_valid)
		else $error("status-only result not marked last");

	// status-only results carry zero payload
	a_empty_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_byte_valid |-> res_value_byte == 8'd0 && res_value_index == 5'd0
			&& res_frame_length == 6'd0)
		else $error("status-only result has payload");

	// errors and progress carry no tag
	a_no_tag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != ST_READY |-> res_frame_tag == 8'd0)
		else $error("tag on non-frame result");

endmodule

bind tlv_frame_decoder_crc16 tlvd_checker u_tlvd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_status       (res.status),
	.res_frame_tag    (res.frame_tag),
	.res_frame_length (res.frame_length),
	.res_value_byte   (res.value_byte),
	.res_value_index  (res.value_index),
	.res_byte_valid   (res.byte_valid),
	.res_last         (res.last)
);

// ===== verif/tlvd_frame_checker.sv =====
`timescale 1ns / 100ps
// Checker for the TLV frame decoder: watches the rx, res and register-write ports,
// decodes each received byte into the results it must cause and compares them in order.
// Depends on tlvd_pkg (codes, widths, reset values) and the tlvd_ifs interfaces.
module tlvd_frame_checker
	import tlvd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	tlvd_rx_if                    rx,
	tlvd_res_if                   res,
	output int unsigned           mismatches,
	output int unsigned           pending,
	output int unsigned           results_seen,
	output int unsigned           frames_ok
);

	localparam int unsigned STORE_DEPTH = MAX_VALUE_BYTES_DEF;
	localparam int unsigned PRINT_CAP   = 25;

	typedef struct packed {
		status_t    status;
		logic [7:0] tag;
		logic [5:0] length;
		logic [7:0] vbyte;
		logic [4:0] vidx;
		logic       bvalid;
		logic       last;
	} frame_result_t;

	frame_result_t decoded_q[$];

	// register copies
	logic [7:0]  cfg_start;
	logic [5:0]  cfg_maxlen;

	// parser copy
	phase_t      ph;
	logic [7:0]  hold_tag;
	logic [15:0] hold_len;
	logic [15:0] rcv_cnt;
	logic [7:0]  crc_lo;
	logic [15:0] crc_run;
	logic [7:0]  value_mem[STORE_DEPTH];

	// MSB-first, one data bit per step
	function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] c, input logic [7:0] d);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ d[i];
			c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

	task automatic clear_frame();
		ph       = PH_HUNT;
		hold_tag = '0;
		hold_len = '0;
		rcv_cnt  = '0;
		crc_lo   = '0;
		crc_run  = CRC_INIT;
	endtask

	task automatic add_result(input status_t st, input logic [7:0] tag, input logic [5:0] len,
			input logic [7:0] vb, input logic [4:0] idx, input logic bv, input logic lst);
		frame_result_t r;
		r.status = st;
		r.tag    = tag;
		r.length = len;
		r.vbyte  = vb;
		r.vidx   = idx;
		r.bvalid = bv;
		r.last   = lst;
		decoded_q.push_back(r);
	endtask

	task automatic decode_byte(input logic [7:0] b);
		int unsigned lim;
		int unsigned n;
		logic [7:0]  ftag;
		case (ph)
			PH_HUNT: begin
				if (b == cfg_start) begin
					ph      = PH_TAG;
					crc_run = CRC_INIT;
				end
			end
			PH_TAG: begin
				hold_tag = b;
				crc_run  = crc_ccitt_byte(crc_run, b);
				ph       = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				hold_len = {8'h00, b};
				crc_run  = crc_ccitt_byte(crc_run, b);
				ph       = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				hold_len[15:8] = b;
				crc_run = crc_ccitt_byte(crc_run, b);
				lim = (32'(cfg_maxlen) > STORE_DEPTH) ? STORE_DEPTH : 32'(cfg_maxlen);
				if (32'(hold_len) > lim) begin
					clear_frame();
					add_result(ST_ERROR, 8'h00, 6'd0, 8'h00, 5'd0, 1'b0, 1'b1);
					return;
				end
				rcv_cnt = '0;
				ph = (hold_len == 16'd0) ? PH_CRC_LO : PH_VALUE;
			end
			PH_VALUE: begin
				if (32'(rcv_cnt) < STORE_DEPTH)
					value_mem[rcv_cnt[4:0]] = b;
				crc_run = crc_ccitt_byte(crc_run, b);
				rcv_cnt++;
				if (rcv_cnt >= hold_len)
					ph = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				crc_lo = b;
				ph     = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				if ({b, crc_lo} != crc_run) begin
					clear_frame();
					add_result(ST_ERROR, 8'h00, 6'd0, 8'h00, 5'd0, 1'b0, 1'b1);
					return;
				end
				// good frame: no status result, the value bytes drain instead; zero-length gives one ready result
				ftag = hold_tag;
				n    = (32'(hold_len) > STORE_DEPTH) ? STORE_DEPTH : 32'(hold_len);
				clear_frame();
				frames_ok++;
				if (n == 0)
					add_result(ST_READY, ftag, 6'd0, 8'h00, 5'd0, 1'b0, 1'b1);
				else
					for (int i = 0; i < n; i++)
						add_result(ST_READY, ftag, n[5:0], value_mem[i[4:0]], i[4:0], 1'b1,
							i == n - 1);
				return;
			end
			default: begin
				clear_frame();
				add_result(ST_ERROR, 8'h00, 6'd0, 8'h00, 5'd0, 1'b0, 1'b1);
				return;
			end
		endcase
		add_result(ST_BUSY, 8'h00, 6'd0, 8'h00, 5'd0, 1'b0, 1'b1);
	endtask

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] result %0d: %s got 0x%0h want 0x%0h", $time, results_seen, what,
				got, want);
	endtask

	task automatic check_result();
		frame_result_t w;
		results_seen++;
		if (decoded_q.size() == 0) begin
			flag_mismatch("result with nothing pending, status", res.status, 0);
			return;
		end
		w = decoded_q.pop_front();
		if (res.status != w.status)
			flag_mismatch("status", res.status, w.status);
		if (res.frame_tag != w.tag)
			flag_mismatch("frame_tag", res.frame_tag, w.tag);
		if (res.frame_length != w.length)
			flag_mismatch("frame_length", res.frame_length, w.length);
		if (res.value_byte != w.vbyte)
			flag_mismatch("value_byte", res.value_byte, w.vbyte);
		if (res.value_index != w.vidx)
			flag_mismatch("value_index", res.value_index, w.vidx);
		if (res.byte_valid != w.bvalid)
			flag_mismatch("byte_valid", res.byte_valid, w.bvalid);
		if (res.last != w.last)
			flag_mismatch("last", res.last, w.last);
	endtask

	// results leave at a later edge than the byte that causes them,
	// so the compare runs before the new byte is decoded; a register
	// write lands at the same edge and only affects later bytes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_start  = START_BYTE_RST;
			cfg_maxlen = MAX_LENGTH_RST;
			clear_frame();
			decoded_q.delete();
			mismatches   = 0;
			results_seen = 0;
			frames_ok    = 0;
			pending      = 0;
		end else begin
			if (res.valid && res.ready)
				check_result();
			if (rx.valid && rx.ready)
				decode_byte(rx.rx_byte);
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_START_BYTE: cfg_start = cfg_wdata;
					REG_MAX_LENGTH: cfg_maxlen = cfg_wdata[5:0];
					default: ;
				endcase
			end
			pending = decoded_q.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the TLV frame decoder testbench: clock, reset, byte stream, register writes,
// receiver stalls and the verdict. Checking lives in tlvd_frame_checker.
// Depends on tlvd_pkg, tlvd_ifs, tlv_frame_decoder_crc16 and tlvd_frame_checker.
module tb_top;
	import tlvd_pkg::*;

	// Worst case: ~360 bytes, each draining 32 results from the value store and
	// waiting out a sparse ready pattern, plus sender gaps and long holds.
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned HOLD_CYCLES = 200;
	localparam int unsigned STORE_DEPTH = MAX_VALUE_BYTES_DEF;

	logic clk = 1'b0;
	logic arst_n;

	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	tlvd_rx_if  rx_ch ();
	tlvd_res_if res_ch ();

	int unsigned mismatches;
	int unsigned pending;
	int unsigned results_seen;
	int unsigned frames_ok;

	// stimulus bookkeeping
	int unsigned bytes_sent    = 0;
	int unsigned burst_left    = 0;
	int unsigned hold_requests = 0;
	int unsigned settings_used = 1;
	logic [7:0]  cur_start;
	int unsigned cur_limit;

	always #6 clk = ~clk;

	tlv_frame_decoder_crc16 u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_ch),
		.res       (res_ch)
	);

	tlvd_frame_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.rx           (rx_ch),
		.res          (res_ch),
		.mismatches   (mismatches),
		.pending      (pending),
		.results_seen (results_seen),
		.frames_ok    (frames_ok)
	);

	// Frame builder needs the good CRC; bitwise MSB-first update.
	function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] d);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ d[i];
			c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

	// Mostly short values; zero and the current limit now and then.
	function automatic int unsigned pick_len();
		int unsigned r;
		if (cur_limit == 0)
			return 0;
		r = $urandom_range(0, 19);
		if (r == 0)
			return cur_limit;
		if (r < 4)
			return 0;
		return $urandom_range(1, (cur_limit < 6) ? cur_limit : 6);
	endfunction

	// One byte transfer. Bursts of random length; between bursts valid drops
	// for a random gap (sometimes none, so long back-to-back stretches occur).
	// valid gets exactly one NBA per step: it is only lowered when a gap follows.
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				rx_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	// start, tag, length (LE), n_vals random value bytes, CRC (LE) xor crc_flip.
	// header_only stops after the length bytes (over-length frames).
	// n_vals below the length field makes a broken frame that eats what follows.
	task automatic send_frame(input logic [7:0] tag, input logic [15:0] len_field,
			input int unsigned n_vals, input logic [15:0] crc_flip, input bit header_only);
		logic [15:0] crc;
		logic [7:0]  v;
		crc = CRC_INIT;
		send_byte(cur_start);
		send_byte(tag);
		crc = crc_next(crc, tag);
		send_byte(len_field[7:0]);
		crc = crc_next(crc, len_field[7:0]);
		send_byte(len_field[15:8]);
		crc = crc_next(crc, len_field[15:8]);
		if (!header_only) begin
			repeat (n_vals) begin
				v = 8'($urandom);
				send_byte(v);
				crc = crc_next(crc, v);
			end
			crc ^= crc_flip;
			send_byte(crc[7:0]);
			send_byte(crc[15:8]);
		end
	endtask

	// Sender pause: stop offering and wait until every predicted result is out.
	// The first edge lets the checker account for the last transfer.
	task automatic drain();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// One register setting, then random traffic: mostly well-formed frames with
	// random content, some bad CRCs, over-length headers, noise and broken frames.
	task automatic run_phase(input logic [7:0] start, input logic [5:0] maxlen,
			input int unsigned n_bytes, input bit long_hold);
		int unsigned target;
		int unsigned pick;
		int unsigned len;
		logic [15:0] flip;
		write_reg(REG_START_BYTE, start);
		write_reg(REG_MAX_LENGTH, {2'b00, maxlen});
		cur_start = start;
		cur_limit = (32'(maxlen) > STORE_DEPTH) ? STORE_DEPTH : 32'(maxlen);
		settings_used++;
		// receiver holds off while the sender keeps offering: rx must back up
		if (long_hold)
			hold_requests <= hold_requests + 1;
		target = bytes_sent + n_bytes;
		while (bytes_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 66) begin
				len = pick_len();
				send_frame(8'($urandom), 16'(len), len, 16'h0000, 1'b0);
			end else if (pick < 76) begin
				len  = pick_len();
				flip = 16'($urandom_range(1, 16'hFFFF));
				send_frame(8'($urandom), 16'(len), len, flip, 1'b0);
			end else if (pick < 84) begin
				if (cur_limit < STORE_DEPTH && $urandom_range(0, 1) == 1)
					len = cur_limit + 1 + $urandom_range(0, STORE_DEPTH - cur_limit - 1);
				else
					len = $urandom_range(STORE_DEPTH + 1, 16'hFFFF);
				send_frame(8'($urandom), 16'(len), 0, 16'h0000, 1'b1);
			end else if (pick < 92) begin
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom));
			end else begin
				len = pick_len();
				send_frame(8'($urandom), 16'(len), $urandom_range(0, len), 16'h0000, 1'b0);
			end
		end
	endtask

	// Receiver: ready follows an 8-bit pattern that is redrawn whenever its random
	// span runs out (all-ready stretches included); a hold request forces ready low
	// for HOLD_CYCLES, counted here.
	initial begin : receiver
		logic [7:0]  pat;
		int unsigned slot;
		int unsigned span;
		int unsigned hold_left;
		int unsigned holds_served;
		res_ch.ready = 1'b0;
		pat          = 8'hFF;
		slot         = 0;
		span         = 0;
		hold_left    = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left    = HOLD_CYCLES;
			end
			if (span == 0) begin
				span = $urandom_range(16, 96);
				case ($urandom_range(0, 3))
					0: pat = 8'hFF;
					1: pat = 8'($urandom);
					2: pat = 8'h11;
					default: pat = ~(8'h01 << $urandom_range(0, 7));
				endcase
				if (pat == 8'h00)
					pat = 8'h80;
			end
			span--;
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= pat[slot[2:0]];
			end
			slot++;
		end
	end

	// Watchdog
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results still pending", cycles, pending);
		$display("tlv_frame_decoder_crc16 verification failed");
		$finish;
	end

	initial begin : stimulus
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = REG_START_BYTE;
		cfg_wdata     = '0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = 8'h00;
		cur_start     = START_BYTE_RST;
		cur_limit     = 32'(MAX_LENGTH_RST);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset register values (start 0xAA, limit 32):
		// noise at both byte extremes while hunting
		send_byte(8'h00);
		send_byte(8'hFF);
		// good zero-length frame -> one ready result without a value byte
		send_frame(8'hFF, 16'd0, 0, 16'h0000, 1'b0);
		// length one past the limit -> error, back to hunting
		send_frame(8'h00, 16'd33, 0, 16'h0000, 1'b1);
		// zero-length frame with a flipped CRC bit -> error
		send_frame(8'h01, 16'd0, 0, 16'h8000, 1'b0);
		// good one-byte frame -> one value transfer with last set
		send_frame(8'h5A, 16'd1, 1, 16'h0000, 1'b0);

		// Random phases; each starts with a pause and both register writes.
		run_phase(8'h00, 6'd0, 45, 1'b0);
		run_phase(8'hFF, 6'd32, 70, 1'b1);
		run_phase(8'($urandom), 6'($urandom_range(1, 31)), 60, 1'b0);
		run_phase(START_BYTE_RST, 6'd32, 70, 1'b1);
		run_phase(8'($urandom), 6'($urandom_range(0, 32)), 60, 1'b0);

		drain();
		repeat (16) @(posedge clk);

		$display("covered %0d received bytes over %0d register settings", bytes_sent,
			settings_used);
		$display("%0d results compared, %0d frames passed CRC and drained", results_seen,
			frames_ok);
		if (mismatches == 0 && pending == 0)
			$display("tlv_frame_decoder_crc16 verification clean");
		else
			$display("tlv_frame_decoder_crc16 verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/tlvd_pkg.sv
sv/tlvd_ifs.sv
sv/tlvd_ctrl.sv
sv/tlvd_datapath.sv
sv/tlv_frame_decoder_crc16.sv
sv/tlvd_checker.sv
verif/tlvd_frame_checker.sv
verif/tb_top.sv
